// ===== rtl/core/apid_pkg.sv =====
package apid_pkg;

  // operand widths
  localparam int ERR_W   = 33;  // target - measured, Q17.16
  localparam int DIFF_W  = 34;  // error difference
  localparam int INTEG_W = 48;  // integral, Q16.32 (clamped below 2^47)
  localparam int DERIV_W = 48;  // derivative, Q32.16 saturated
  localparam int DVD_W   = 50;  // |diff| << 16
  localparam int ACC_W   = 98;  // PID sum, Q.48
  localparam int PER_W   = 16;
  localparam int RPM_W   = 16;
  localparam int MUL_STEPS = 48;

  // configuration register indexes
  localparam logic [7:0] REG_PROP_GAIN   = 8'd0;
  localparam logic [7:0] REG_INTEG_GAIN  = 8'd1;
  localparam logic [7:0] REG_DERIV_GAIN  = 8'd2;
  localparam logic [7:0] REG_INTEG_LIMIT = 8'd3;
  localparam logic [7:0] REG_ERROR_BAND  = 8'd4;
  localparam logic [7:0] REG_HOVER_SPEED = 8'd5;
  localparam logic [7:0] REG_MIN_RPM     = 8'd6;
  localparam logic [7:0] REG_MAX_RPM     = 8'd7;

  // commands
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [30:0] BAND_RESET = 31'd327680;

endpackage

// ===== rtl/core/apid_div.sv =====
module apid_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [apid_pkg::DIFF_W-1:0]  diff,
  input  logic [apid_pkg::PER_W-1:0]          per,
  output logic                                done,
  output logic signed [apid_pkg::DERIV_W-1:0] deriv
);
  import apid_pkg::*;

  localparam logic [DVD_W-1:0] Q_POS_MAX = {{(DVD_W-DERIV_W+1){1'b0}}, {(DERIV_W-1){1'b1}}};
  localparam logic [DVD_W-1:0] Q_NEG_MAX = Q_POS_MAX + 1'b1;
  localparam logic signed [DERIV_W-1:0] D_MAX = {1'b0, {(DERIV_W-1){1'b1}}};
  localparam logic signed [DERIV_W-1:0] D_MIN = {1'b1, {(DERIV_W-1){1'b0}}};

  logic             busy;
  logic [5:0]       cnt;
  logic             neg;
  logic [DVD_W-1:0] dvd;
  logic [DVD_W-1:0] quo;
  logic [PER_W-1:0] rem;
  logic [PER_W-1:0] dsr;
  logic [PER_W:0]   rem_sh;
  logic             fit;
  logic [DIFF_W-1:0] diff_mag;

  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign rem_sh   = {rem, dvd[DVD_W-1]};
  assign fit      = rem_sh >= {1'b0, dsr};

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      if (diff == '0) begin
        deriv <= '0;
        done  <= 1'b1;
        busy  <= 1'b0;
      end else begin
        busy <= 1'b1;
        cnt  <= 6'(DVD_W - 1);
        neg  <= diff[DIFF_W-1];
        dvd  <= {diff_mag, 16'b0};
        quo  <= '0;
        rem  <= '0;
        dsr  <= per;
      end
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      if (fit) begin
        rem <= PER_W'(rem_sh - {1'b0, dsr});
      end else begin
        rem <= rem_sh[PER_W-1:0];
      end
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
        // saturate to signed 48 bits
        if (neg) begin
          if ({quo[DVD_W-2:0], fit} > Q_NEG_MAX) deriv <= D_MIN;
          else deriv <= DERIV_W'(-{quo[DVD_W-2:0], fit});
        end else begin
          if ({quo[DVD_W-2:0], fit} > Q_POS_MAX) deriv <= D_MAX;
          else deriv <= DERIV_W'({quo[DVD_W-2:0], fit});
        end
      end else begin
        cnt <= cnt - 1'b1;
      end
      quo <= {quo[DVD_W-2:0], fit};
    end
  end

endmodule

// ===== rtl/core/altitude_pid_with_band_antiwindup_top.sv =====
// A step item passes through a prep state, bit-serial division by the period
// (a short path when the error difference is zero), a shift-add multiply (three
// 48-bit passes) and an output state that holds while the previous result waits
// for m_tready. A new item is accepted only once the previous step item is done;
// a clear item gives no result.
// Reset (rst, synchronous): state cleared, registers at their reset values.
module altitude_pid_with_band_antiwindup_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // target_height[31:0], measured_height[63:32], period[79:64]
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // drive_rpm[15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import apid_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_DIV, S_MUL, S_FIN} state_t;

  state_t state;

  // configuration
  logic [31:0] prop_gain, integ_gain, deriv_gain;
  logic [30:0] integ_limit, error_band;
  logic [15:0] hover_speed, min_rpm, max_rpm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      integ_limit <= '0;
      error_band  <= BAND_RESET;
      hover_speed <= '0;
      min_rpm     <= '0;
      max_rpm     <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROP_GAIN:   prop_gain   <= cfg_data;
        REG_INTEG_GAIN:  integ_gain  <= cfg_data;
        REG_DERIV_GAIN:  deriv_gain  <= cfg_data;
        REG_INTEG_LIMIT: integ_limit <= cfg_data[30:0];
        REG_ERROR_BAND:  error_band  <= cfg_data[30:0];
        REG_HOVER_SPEED: hover_speed <= cfg_data[15:0];
        REG_MIN_RPM:     min_rpm     <= cfg_data[15:0];
        REG_MAX_RPM:     max_rpm     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // controller state and working registers
  logic signed [INTEG_W-1:0] integ_acc;
  logic signed [ERR_W-1:0]   last_error;
  logic                      primed_flag;
  logic signed [ERR_W-1:0]   err;
  logic [PER_W-1:0]          per;
  logic signed [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]          mcand;
  logic [MUL_STEPS-1:0]      mplier;
  logic                      mneg;
  logic [1:0]                term;
  logic [5:0]                mcnt;

  // accept-side error
  logic signed [ERR_W-1:0] in_err;
  assign in_err = ERR_W'($signed(s_tdata[31:0])) - ERR_W'($signed(s_tdata[63:32]));
  assign s_tready = (state == S_IDLE);

  // integral update, evaluated in the prep cycle
  logic [ERR_W-1:0]          err_mag;
  logic                      in_band;
  logic signed [49:0]        inc;
  logic signed [50:0]        isum;
  logic signed [50:0]        ilim;
  logic signed [INTEG_W-1:0] integ_next;

  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign in_band = (error_band == '0) || (err_mag <= {2'b0, error_band});
  assign inc     = 50'(err * $signed({1'b0, per}));
  assign isum    = 51'(integ_acc) + 51'(inc);
  assign ilim    = $signed({4'b0, integ_limit, 16'b0});

  always_comb begin
    if (!in_band) integ_next = integ_acc;
    else if (isum > ilim) integ_next = INTEG_W'(ilim);
    else if (isum < -ilim) integ_next = INTEG_W'(-ilim);
    else integ_next = INTEG_W'(isum);
  end

  // derivative divider
  logic                      div_start;
  logic                      div_done;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DERIV_W-1:0] deriv;

  assign div_start = (state == S_PREP);
  assign diff = primed_flag ? (DIFF_W'(err) - DIFF_W'(last_error)) : '0;

  apid_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .diff  (diff),
    .per   (per),
    .done  (div_done),
    .deriv (deriv)
  );

  // shift-add step
  logic signed [ACC_W-1:0] acc_step;
  always_comb begin
    acc_step = acc;
    if (mplier[0]) acc_step = mneg ? acc - $signed(mcand) : acc + $signed(mcand);
  end

  // final scaling and clamp
  logic                acc_neg;
  logic [ACC_W-1:0]    acc_mag;
  logic [49:0]         ipart;
  logic signed [51:0]  rsum;
  logic [RPM_W-1:0]    rpm;

  assign acc_neg = acc[ACC_W-1];
  assign acc_mag = acc_neg ? ACC_W'(-acc) : ACC_W'(acc);
  assign ipart   = acc_mag[ACC_W-1:48];
  assign rsum    = acc_neg ? $signed({36'b0, hover_speed}) - $signed({2'b0, ipart})
                           : $signed({36'b0, hover_speed}) + $signed({2'b0, ipart});
  always_comb begin
    if (rsum > $signed({36'b0, max_rpm})) rpm = max_rpm;
    else rpm = rsum[RPM_W-1:0];
    if (rsum < $signed({36'b0, min_rpm}) || (rsum > $signed({36'b0, max_rpm}) && min_rpm > max_rpm))
      rpm = min_rpm;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      integ_acc   <= '0;
      last_error  <= '0;
      primed_flag <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // result taken; the output state sets it again itself
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == CMD_CLEAR) begin
              integ_acc   <= '0;
              last_error  <= '0;
              primed_flag <= 1'b0;
            end else begin
              err   <= in_err;
              per   <= s_tdata[79:64];
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          integ_acc   <= integ_next;
          last_error  <= err;
          primed_flag <= 1'b1;
          state       <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            acc    <= '0;
            term   <= 2'd0;
            mcnt   <= '0;
            mneg   <= err[ERR_W-1];
            mplier <= MUL_STEPS'(err_mag);
            mcand  <= {50'b0, prop_gain, 16'b0};
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          acc <= acc_step;
          if (mcnt == 6'(MUL_STEPS - 1)) begin
            mcnt <= '0;
            term <= term + 1'b1;
            case (term)
              2'd0: begin
                mneg   <= integ_acc[INTEG_W-1];
                mplier <= integ_acc[INTEG_W-1] ? MUL_STEPS'(-integ_acc) : MUL_STEPS'(integ_acc);
                mcand  <= {66'b0, integ_gain};
              end
              2'd1: begin
                mneg   <= deriv[DERIV_W-1];
                mplier <= deriv[DERIV_W-1] ? MUL_STEPS'(-deriv) : MUL_STEPS'(deriv);
                mcand  <= {50'b0, deriv_gain, 16'b0};
              end
              default: state <= S_FIN;
            endcase
          end else begin
            mcnt   <= mcnt + 1'b1;
            mplier <= mplier >> 1;
            mcand  <= mcand << 1;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= rpm;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import apid_pkg::*;

  typedef struct {
    logic               cmd;
    logic signed [31:0] tgt;
    logic signed [31:0] meas;
    logic [15:0]        per;
  } alt_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  altitude_pid_with_band_antiwindup_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // controller copy: registers and loop memory
  logic [31:0] kp, ki, kd;
  logic [30:0] i_limit, band;
  logic [15:0] hover, rpm_lo, rpm_hi;
  longint      integ;
  longint      prev_err;
  bit          primed;

  alt_item_t   pending_items[$];
  logic [15:0] rpm_expected[$];
  int          errors = 0;
  int          rx_mode = 0;
  bit          long_hold_req = 1'b0;

  // one accepted item: update loop memory and, for a step, queue the expected rpm
  function automatic void step_altitude(alt_item_t it);
    longint e, diff, d, lim, s;
    logic signed [127:0] acc, ip, r;
    if (it.cmd == CMD_CLEAR) begin
      integ = 0; prev_err = 0; primed = 1'b0;
      return;
    end
    e = longint'(it.tgt) - longint'(it.meas);
    if (!primed) begin
      prev_err = e; primed = 1'b1;
    end
    diff = e - prev_err;
    if (it.per == 0)
      d = diff > 0 ? 64'sh7FFF_FFFF_FFFF : (diff < 0 ? -64'sh8000_0000_0000 : 0);
    else begin
      d = (diff * 65536) / longint'({48'b0, it.per});
      if (d > 64'sh7FFF_FFFF_FFFF) d = 64'sh7FFF_FFFF_FFFF;
      if (d < -64'sh8000_0000_0000) d = -64'sh8000_0000_0000;
    end
    prev_err = e;
    if (band == 0 || (e < 0 ? -e : e) <= longint'({33'b0, band})) begin
      lim = longint'({33'b0, i_limit}) * 65536;
      s = integ + e * longint'({48'b0, it.per});
      if (s > lim) s = lim;
      if (s < -lim) s = -lim;
      integ = s;
    end
    acc = $signed({96'b0, kp}) * 128'(e) * 65536
        + $signed({96'b0, ki}) * 128'(integ)
        + $signed({96'b0, kd}) * 128'(d) * 65536;
    ip = acc / 128'sh1_0000_0000_0000;
    r = $signed({112'b0, hover}) + ip;
    if (r > $signed({112'b0, rpm_hi})) r = $signed({112'b0, rpm_hi});
    if (r < $signed({112'b0, rpm_lo})) r = $signed({112'b0, rpm_lo});
    rpm_expected.push_back(r[15:0]);
  endfunction

  // sender: bursts of items with random gaps
  alt_item_t cur_item;
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) step_altitude(cur_item);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          s_tdata <= {cur_item.per, cur_item.meas, cur_item.tgt};
          s_tuser <= cur_item.cmd;
          s_tvalid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                  : $urandom_range(0, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern per phase, plus one long hold-off on request
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  int  rx_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = 5000;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      rx_phase = (rx_phase + 1) % 11;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 2) != 0);
        default: m_tready <= (rx_phase > 3);
      endcase
    end
  end

  // checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (rpm_expected.size() == 0) begin
        errors++;
        $display("%0t: drive_rpm expected none, actual %0d", $time, m_tdata);
      end else begin
        logic [15:0] want;
        want = rpm_expected.pop_front();
        if (m_tdata !== want) begin
          errors++;
          $display("%0t: drive_rpm expected %0d, actual %0d", $time, want, m_tdata);
        end
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_PROP_GAIN:   kp = val;
      REG_INTEG_GAIN:  ki = val;
      REG_DERIV_GAIN:  kd = val;
      REG_INTEG_LIMIT: i_limit = val[30:0];
      REG_ERROR_BAND:  band = val[30:0];
      REG_HOVER_SPEED: hover = val[15:0];
      REG_MIN_RPM:     rpm_lo = val[15:0];
      REG_MAX_RPM:     rpm_hi = val[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                           logic [31:0] lim, logic [31:0] bw,
                           logic [31:0] hv, logic [31:0] lo, logic [31:0] hi);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_INTEG_LIMIT, lim);
    write_reg(REG_ERROR_BAND, bw);
    write_reg(REG_HOVER_SPEED, hv);
    write_reg(REG_MIN_RPM, lo);
    write_reg(REG_MAX_RPM, hi);
  endtask

  // wait for the loop to drain; a trailing clear gives no result, so pad
  task automatic wait_idle();
    while (pending_items.size() > 0 || s_tvalid || rpm_expected.size() > 0)
      @(posedge clk);
    repeat (260) @(posedge clk);
  endtask

  function automatic void add_item(logic c, logic [31:0] t, logic [31:0] m, logic [15:0] p);
    alt_item_t it;
    it.cmd = c; it.tgt = t; it.meas = m; it.per = p;
    pending_items.push_back(it);
  endfunction

  // mostly tracking steps near the setpoint, some wild jumps and clears
  function automatic void add_random(int n);
    logic [31:0] m, off;
    logic [15:0] p;
    repeat (n) begin
      m = $urandom();
      case ($urandom_range(0, 9))
        0: off = $urandom();
        1, 2: off = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        default: off = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      endcase
      p = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                      : 16'($urandom_range(1, 2000));
      add_item(($urandom_range(0, 24) == 0) ? CMD_CLEAR : CMD_STEP, m + off, m, p);
    end
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0000_FFFF);
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  initial begin
    kp = '0; ki = '0; kd = '0; i_limit = '0; band = BAND_RESET;
    hover = '0; rpm_lo = '0; rpm_hi = 16'hFFFF;
    integ = 0; prev_err = 0; primed = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset registers first, then a moderate setting
    add_item(CMD_STEP, 32'h0001_0000, 32'h0000_0000, 16'd1000);
    wait_idle();
    write_all(32'h0010_0000, 32'h0001_0000, 32'h0000_8000, 32'h0005_0000,
              32'h0005_0000, 32'd3000, 32'd1000, 32'd9000);
    write_reg(8'd9, 32'hFFFF_FFFF);
    add_item(CMD_STEP, 32'h0000_0000, 32'h0000_0000, 16'd1);
    add_item(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
    add_item(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
    add_item(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    add_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    add_item(CMD_STEP, 32'h0005_0000, 32'h0000_0000, 16'hFFFF);
    add_item(CMD_STEP, 32'h0005_0001, 32'h0000_0000, 16'hFFFF);
    add_item(CMD_STEP, 32'h0000_0000, 32'h0005_0000, 16'h8000);
    add_item(CMD_STEP, 32'h0000_0000, 32'h0005_0001, 16'h0001);
    add_item(CMD_STEP, 32'h0002_0000, 32'h0000_0000, 16'hFFFF);
    add_item(CMD_STEP, 32'h0002_0000, 32'h0000_0000, 16'hFFFF);
    add_item(CMD_STEP, 32'h0002_0000, 32'h0000_0000, 16'hFFFF);
    add_item(CMD_STEP, 32'hFFFE_0000, 32'h0000_0000, 16'h5555);
    add_item(CMD_STEP, 32'h1234_5678, 32'h1234_5678, 16'hAAAA);
    add_item(CMD_CLEAR, 32'h0, 32'h0, 16'h0001);
    wait_idle();

    // extremes: full gains, widest clamp, band off
    rx_mode = 1;
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
              32'h0, 32'hFFFF, 32'h0, 32'hFFFF);
    add_item(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    add_item(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
    add_random(120);
    wait_idle();

    // zero gains, zero limit, widest band, min above max
    rx_mode = 2;
    write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'd0, 32'd500, 32'd200);
    add_random(60);
    wait_idle();

    // random settings; one phase with a long receiver hold-off
    for (int ph = 0; ph < 5; ph++) begin
      rx_mode = ph % 3;
      write_all(rand_gain(), rand_gain(), rand_gain(), $urandom_range(0, 32'h00FF_FFFF),
                ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom_range(0, 32'h00FF_FFFF),
                $urandom_range(0, 65535), $urandom_range(0, 20000),
                $urandom_range(20000, 65535));
      if (ph == 1) long_hold_req = 1'b1;
      add_random(60);
      // sender pauses here until every result is back
      while (pending_items.size() > 0 || s_tvalid || rpm_expected.size() > 0)
        @(posedge clk);
      add_random(60);
      wait_idle();
    end

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
